/* src/i2ctrm_pkg.sv */
package i2ctrm_pkg;

  localparam int MAP_SIZE = 64;
  localparam int ADDR_W = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam logic [8:0] MAP_END = 9'(MAP_SIZE);

  localparam int CFG_ADDR_W = 4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0] data8_t;

  typedef enum logic [2:0] {
    K_START = 3'd0,
    K_STOP = 3'd1,
    K_BYTE = 3'd2,
    K_TX = 3'd3,
    K_WORD_RD = 3'd4,
    K_WORD_WR = 3'd5
  } kind_t;

  localparam logic [1:0] REG_RO_START = 2'd0;
  localparam logic [1:0] REG_CMD_INDEX = 2'd1;
  localparam logic [1:0] REG_FILL = 2'd2;

  localparam logic [6:0] RO_START_RST = 7'd32;
  localparam logic [7:0] CMD_INDEX_RST = 8'd0;
  localparam logic [7:0] FILL_RST = 8'hff;

  typedef struct packed {
    logic [6:0] readonly_start;
    logic [7:0] command_index;
    logic [7:0] fill_value;
  } cfg_t;

  typedef struct packed {
    logic we;
    addr_t waddr;
    data8_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic command_strobe;
    logic [7:0] command_value;
    logic [15:0] word_out;
  } result_t;

endpackage

/* src/i2c_target_register_map.sv */
// Channel  Handshake              Payload
// input    in_valid / in_ready    kind, rx_byte, word_index, word_value
// output   out_valid / out_ready  tx_byte, command_strobe, command_value, word_out
// config   APB psel / penable     paddr, pwdata, pwrite, prdata, pready
//
// Start, stop, received bytes, unused kinds, a transmit outside the map and a word
// access out of range go from the execute state to done; a transmit inside the map
// waits for the registered map read, a word write in range writes its high byte in
// a further state, and a word read in range reads the byte-wide map low then high.
// Reset is synchronous and leaves the map reading as zero at once.
// A result waits in the output register while the next item is accepted, and
// that item finishes only once the output register is free.
module i2c_target_register_map
  import i2ctrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            kind,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            word_index,
  input  logic [15:0]           word_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            tx_byte,
  output logic                  command_strobe,
  output logic [7:0]            command_value,
  output logic [15:0]           word_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  mem_req_t req;
  data8_t rdata;
  result_t out_res;

  i2ctrm_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  i2ctrm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .rx_byte(rx_byte),
    .word_index(word_index),
    .word_value(word_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res),
    .req(req),
    .rdata(rdata)
  );

  i2ctrm_store u_store (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rdata(rdata)
  );

  assign tx_byte = out_res.tx_byte;
  assign command_strobe = out_res.command_strobe;
  assign command_value = out_res.command_value;
  assign word_out = out_res.word_out;

endmodule

/* src/i2ctrm_ram.sv */
module i2ctrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/i2ctrm_store.sv */
module i2ctrm_store
  import i2ctrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output data8_t   rdata
);

  logic [MAP_SIZE-1:0] valid;
  logic rvalid;
  data8_t ram_q;

  i2ctrm_ram #(
    .WIDTH(8),
    .DEPTH(MAP_SIZE)
  ) u_ram (
    .clk(clk),
    .we(req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rvalid <= valid[req.raddr];
    end
  end

  assign rdata = rvalid ? ram_q : 8'd0;

endmodule

/* src/i2ctrm_cfg.sv */
module i2ctrm_cfg
  import i2ctrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;
  logic [1:0] reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.readonly_start <= RO_START_RST;
      cfg.command_index <= CMD_INDEX_RST;
      cfg.fill_value <= FILL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RO_START: cfg.readonly_start <= pwdata[6:0];
        REG_CMD_INDEX: cfg.command_index <= pwdata[7:0];
        REG_FILL: cfg.fill_value <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RO_START: prdata = {25'd0, cfg.readonly_start};
      REG_CMD_INDEX: prdata = {24'd0, cfg.command_index};
      REG_FILL: prdata = {24'd0, cfg.fill_value};
      default: prdata = 32'd0;
    endcase
  end

endmodule

/* src/i2ctrm_ctrl.sv */
module i2ctrm_ctrl
  import i2ctrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  word_index,
  input  logic [15:0] word_value,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output mem_req_t    req,
  input  data8_t      rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TX_WAIT,
    S_RD_LO,
    S_RD_HI,
    S_WR_HI,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_STOPPED,
    PH_START,
    PH_REGSET,
    PH_COMMAND
  } phase_t;

  state_t state;
  state_t exec_next;
  phase_t phase;
  logic [7:0] pointer;
  result_t res;

  kind_t it_kind;
  logic [7:0] it_rx;
  logic [7:0] it_widx;
  logic [15:0] it_wval;

  logic out_free;
  logic accept;
  logic ptr_in_map;
  logic rx_ok;
  logic word_ok;
  logic [8:0] ptr_inc;
  logic [7:0] ptr_step;
  logic [8:0] widx_hi;

  always_comb begin
    out_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
    accept = in_valid && in_ready;
    ptr_in_map = {1'b0, pointer} < MAP_END;
    rx_ok = ptr_in_map && ({1'b0, pointer} < {2'b00, cfg.readonly_start});
    ptr_inc = {1'b0, pointer} + 9'd1;
    ptr_step = (ptr_inc >= MAP_END) ? 8'd0 : ptr_inc[7:0];
    widx_hi = {1'b0, it_widx} + 9'd1;
    word_ok = widx_hi < MAP_END;
    exec_next = S_DONE;
    case (it_kind)
      K_TX: begin
        if (ptr_in_map) begin
          exec_next = S_TX_WAIT;
        end
      end
      K_WORD_RD: begin
        if (word_ok) begin
          exec_next = S_RD_LO;
        end
      end
      K_WORD_WR: begin
        if (word_ok) begin
          exec_next = S_WR_HI;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    req = '0;
    case (state)
      S_EXEC: begin
        case (it_kind)
          K_BYTE: begin
            if ((phase == PH_REGSET) && rx_ok) begin
              req.we = 1'b1;
              req.waddr = pointer[ADDR_W-1:0];
              req.wdata = it_rx;
            end
          end
          K_TX: req.raddr = pointer[ADDR_W-1:0];
          K_WORD_RD: req.raddr = it_widx[ADDR_W-1:0];
          K_WORD_WR: begin
            if (word_ok) begin
              req.we = 1'b1;
              req.waddr = it_widx[ADDR_W-1:0];
              req.wdata = it_wval[7:0];
            end
          end
          default: ;
        endcase
      end
      S_RD_LO: req.raddr = widx_hi[ADDR_W-1:0];
      S_WR_HI: begin
        req.we = 1'b1;
        req.waddr = widx_hi[ADDR_W-1:0];
        req.wdata = it_wval[15:8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_kind <= kind_t'(kind);
      it_rx <= rx_byte;
      it_widx <= word_index;
      it_wval <= word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_STOPPED;
      pointer <= 8'd0;
      out_valid <= 1'b0;
      res <= '0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= exec_next;
          case (it_kind)
            K_START: phase <= PH_START;
            K_STOP: phase <= PH_STOPPED;
            K_BYTE: begin
              case (phase)
                PH_START: begin
                  pointer <= it_rx;
                  phase <= (it_rx == cfg.command_index) ? PH_COMMAND : PH_REGSET;
                end
                PH_REGSET: begin
                  if (rx_ok) begin
                    pointer <= pointer + 8'd1;
                  end
                end
                PH_COMMAND: begin
                  {res.command_strobe, res.command_value} <= {1'b1, it_rx};
                end
                default: ;
              endcase
            end
            K_TX: begin
              pointer <= ptr_step;
              if (!ptr_in_map) begin
                res.tx_byte <= cfg.fill_value;
              end
            end
            default: ;
          endcase
        end
        S_TX_WAIT: begin
          res.tx_byte <= rdata;
          state <= S_DONE;
        end
        S_RD_LO: begin
          res.word_out[7:0] <= rdata;
          state <= S_RD_HI;
        end
        S_RD_HI: begin
          res.word_out[15:8] <= rdata;
          state <= S_DONE;
        end
        S_WR_HI: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_res <= res;
            res <= '0;
            state <= accept ? S_EXEC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/i2ctrm_checker.sv */
module i2ctrm_checker
  import i2ctrm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [2:0]            kind,
  input logic [7:0]            rx_byte,
  input logic [7:0]            word_index,
  input logic [15:0]           word_value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [7:0]            tx_byte,
  input logic                  command_strobe,
  input logic [7:0]            command_value,
  input logic [15:0]           word_out,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(word_out))
    else $error("output beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_cmd_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_strobe |-> tx_byte == 8'd0 && word_out == 16'd0)
    else $error("command beat carries other results");

  a_cmd_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_strobe |-> command_value == 8'd0)
    else $error("command value without strobe");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat right after reset");

endmodule

bind i2c_target_register_map i2ctrm_checker u_checker (.*);
